[rtl/tifr_pkg.sv]
package tifr_pkg;

    localparam logic [7:0] IAC_BYTE = 8'hFF;
    localparam logic [7:0] CMD_WILL = 8'hFB;
    localparam logic [7:0] CMD_DO   = 8'hFD;
    localparam logic [7:0] CMD_WONT = 8'hFC;
    localparam logic [7:0] CMD_DONT = 8'hFE;
    localparam logic [7:0] OPT_SGA  = 8'h03;
    localparam logic [7:0] OPT_ECHO = 8'h01;
    localparam logic [7:0] NUL_BYTE = 8'h00;

    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_RESET = 1'b1;

    localparam logic DEST_HOST = 1'b0;
    localparam logic DEST_PEER = 1'b1;

    // one queued job: a host byte, or a three-byte reply to the peer
    typedef struct packed {
        logic       is_reply;
        logic [7:0] data_byte;
        logic [7:0] reply_cmd;
    } t_entry;

endpackage

[rtl/tifr_if.sv]
interface tifr_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface tifr_out_if;
    logic       valid;
    logic       ready;
    logic       dest;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output dest, output out_byte, output last, input ready);
    modport sink   (input valid, input dest, input out_byte, input last, output ready);
endinterface

[rtl/telnet_iac_filter_responder_unit.sv]
// channel  | dir | handshake     | payload
// i_in     | in  | valid / ready | action, rx_byte
// o_out    | out | valid / ready | dest, out_byte, last
//
// one request per cycle is taken while the queue has room; items that give no
// result never enter the queue. results leave from an output register loaded
// from the queue head; a peer reply is three bytes: iac, command, option.
// the queue (P_QUEUE_DEPTH entries) lets input run on while output stalls.
// reset is synchronous, active low; it empties the queue and clears the phase.
module telnet_iac_filter_responder_unit #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tifr_in_if.sink     i_in,
    tifr_out_if.source  o_out
);

    tifr_pkg::t_entry w_push_entry;
    tifr_pkg::t_entry w_head_entry;
    logic             w_push;
    logic             w_full;
    logic             w_pop;
    logic             w_not_empty;

    tifr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    tifr_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_wdata     (w_push_entry),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_not_empty (w_not_empty),
        .o_rdata     (w_head_entry)
    );

    tifr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_not_empty (w_not_empty),
        .i_entry     (w_head_entry),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );

endmodule

[rtl/tifr_front.sv]
module tifr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tifr_in_if.sink          i_in,
    input  logic             i_full,
    output logic             o_push,
    output tifr_pkg::t_entry o_entry
);

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_AFTER_IAC,
        PH_OPTION
    } t_phase;

    t_phase     r_phase,   n_phase;
    logic [7:0] r_saved,   n_saved;
    logic       r_prev_nul, n_prev_nul;
    logic       w_accept;
    logic [7:0] w_b;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_b        = i_in.rx_byte;

    always_comb begin
        n_phase            = r_phase;
        n_saved            = r_saved;
        n_prev_nul         = r_prev_nul;
        o_push             = 1'b0;
        o_entry.is_reply   = 1'b0;
        o_entry.data_byte  = w_b;
        o_entry.reply_cmd  = tifr_pkg::CMD_WILL;
        if (w_accept) begin
            if (i_in.action == tifr_pkg::ACT_RESET) begin
                n_phase = PH_NORMAL;
            end else begin
                case (r_phase)
                    PH_AFTER_IAC: begin
                        if (w_b == tifr_pkg::IAC_BYTE) begin
                            n_phase = PH_NORMAL;
                            o_push  = 1'b1;
                        end else begin
                            n_saved = w_b;
                            n_phase = PH_OPTION;
                        end
                    end
                    PH_OPTION: begin
                        o_entry.is_reply = 1'b1;
                        case (r_saved)
                            tifr_pkg::CMD_WILL: begin
                                o_push            = (w_b == tifr_pkg::OPT_SGA);
                                o_entry.reply_cmd = tifr_pkg::CMD_DO;
                            end
                            tifr_pkg::CMD_DO: begin
                                o_push = w_b inside {tifr_pkg::OPT_SGA, tifr_pkg::OPT_ECHO};
                                o_entry.reply_cmd = tifr_pkg::CMD_WILL;
                            end
                            tifr_pkg::CMD_WONT: begin
                                o_push            = 1'b1;
                                o_entry.reply_cmd = tifr_pkg::CMD_DONT;
                            end
                            tifr_pkg::CMD_DONT: begin
                                o_push            = 1'b1;
                                o_entry.reply_cmd = tifr_pkg::CMD_WILL;
                            end
                            default: begin
                                o_push = 1'b0;
                            end
                        endcase
                        n_saved = '0;
                        n_phase = PH_NORMAL;
                    end
                    default: begin
                        n_phase = PH_NORMAL;
                        if (w_b == tifr_pkg::IAC_BYTE) begin
                            n_phase = PH_AFTER_IAC;
                        end else if (w_b != tifr_pkg::NUL_BYTE || r_prev_nul) begin
                            n_prev_nul = 1'b0;
                            o_push     = 1'b1;
                        end else begin
                            // lone nul is dropped, a second one goes through
                            n_prev_nul = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_NORMAL;
            r_saved    <= '0;
            r_prev_nul <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_saved    <= n_saved;
            r_prev_nul <= n_prev_nul;
        end
    end

endmodule

[rtl/tifr_queue.sv]
module tifr_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tifr_pkg::t_entry i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_not_empty,
    output tifr_pkg::t_entry o_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tifr_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             w_push, w_pop;

    assign o_full      = (r_count == CW'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_rdata     = r_mem[r_rd_ptr];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_pop && o_not_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

[rtl/tifr_back.sv]
module tifr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_not_empty,
    input  tifr_pkg::t_entry i_entry,
    output logic             o_pop,
    tifr_out_if.source       o_out
);

    typedef enum logic [1:0] {
        BEAT_IAC,
        BEAT_CMD,
        BEAT_OPT
    } t_beat;

    t_beat      r_beat, n_beat;
    logic       r_valid, n_valid;
    logic       r_dest,  n_dest;
    logic [7:0] r_byte,  n_byte;
    logic       r_last,  n_last;
    logic       w_load;
    logic       w_final;

    assign w_load = !r_valid || o_out.ready;

    always_comb begin
        n_beat  = r_beat;
        n_valid = r_valid;
        n_dest  = r_dest;
        n_byte  = r_byte;
        n_last  = r_last;
        w_final = 1'b0;
        if (w_load) begin
            n_valid = i_not_empty;
            if (!i_entry.is_reply) begin
                n_dest  = tifr_pkg::DEST_HOST;
                n_byte  = i_entry.data_byte;
                n_last  = 1'b1;
                w_final = 1'b1;
            end else begin
                n_dest = tifr_pkg::DEST_PEER;
                case (r_beat)
                    BEAT_IAC: begin
                        n_byte = tifr_pkg::IAC_BYTE;
                        n_last = 1'b0;
                        n_beat = i_not_empty ? BEAT_CMD : BEAT_IAC;
                    end
                    BEAT_CMD: begin
                        n_byte = i_entry.reply_cmd;
                        n_last = 1'b0;
                        n_beat = BEAT_OPT;
                    end
                    default: begin
                        n_byte  = i_entry.data_byte;
                        n_last  = 1'b1;
                        w_final = 1'b1;
                        n_beat  = BEAT_IAC;
                    end
                endcase
            end
        end
    end

    assign o_pop = w_load && i_not_empty && w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat  <= BEAT_IAC;
            r_valid <= 1'b0;
        end else begin
            r_beat  <= n_beat;
            r_valid <= n_valid;
        end
        r_dest <= n_dest;
        r_byte <= n_byte;
        r_last <= n_last;
    end

    assign o_out.valid    = r_valid;
    assign o_out.dest     = r_dest;
    assign o_out.out_byte = r_byte;
    assign o_out.last     = r_last;

endmodule

[rtl/tifr_checker.sv]
module tifr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_dest,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    logic [1:0] r_reply_beat;
    logic       w_out_accept;

    assign w_out_accept = i_out_valid && i_out_ready;

    // counts accepted bytes within a peer reply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reply_beat <= '0;
        end else if (w_out_accept && i_out_dest == tifr_pkg::DEST_PEER) begin
            r_reply_beat <= i_out_last ? 2'd0 : r_reply_beat + 2'd1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_dest)
            && $stable(i_out_byte) && $stable(i_out_last))
        else $error("output changed while stalled");

    a_host_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_dest == tifr_pkg::DEST_HOST |-> i_out_last
            && r_reply_beat == 2'd0)
        else $error("host byte not single or inside a reply");

    a_reply_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_dest == tifr_pkg::DEST_PEER && r_reply_beat == 2'd0
            |-> i_out_byte == tifr_pkg::IAC_BYTE && !i_out_last)
        else $error("reply does not open with iac");

    a_reply_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_dest == tifr_pkg::DEST_PEER
            |-> i_out_last == (r_reply_beat == 2'd2))
        else $error("reply length is not three bytes");

endmodule

bind telnet_iac_filter_responder_unit tifr_checker u_tifr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_dest  (o_out.dest),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);
